FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// HATQP_ASSERT_RST: checked only while out of reset.
// HATQP_ASSERT_ALL: checked at every edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HATQP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HATQP_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HATQP_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define HATQP_ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/hatqp_pkg.sv
package hatqp_pkg;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int COEF_W   = 32;
    localparam int EXPO_W   = 16;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;

    // Table size after reset
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1021;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // One table slot as stored in memory
    typedef struct packed {
        logic                     occupied;
        logic [EXPO_W-1:0]        expo;
        logic signed [COEF_W-1:0] coef;
    } entry_t;

endpackage

FILE: hw/rtl/hatqp_if.sv
// Command channel: one beat per action
interface hatqp_cmd_if;
    import hatqp_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [ACTION_W-1:0]         action;
    logic signed [COEF_W-1:0]    coefficient;
    logic [EXPO_W-1:0]           exponent;
    logic [INDEX_W-1:0]          slot_index;

    modport source (output valid, action, coefficient, exponent, slot_index, input ready);
    modport sink   (input valid, action, coefficient, exponent, slot_index, output ready);
endinterface

// Response channel: one beat per command
interface hatqp_rsp_if;
    import hatqp_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic                        slot_valid;
    logic signed [COEF_W-1:0]    slot_coefficient;
    logic [EXPO_W-1:0]           slot_exponent;
    logic [INDEX_W-1:0]          slot_position;

    modport source (output valid, status, slot_valid, slot_coefficient, slot_exponent,
                    slot_position, input ready);
    modport sink   (input valid, status, slot_valid, slot_coefficient, slot_exponent,
                    slot_position, output ready);
endinterface

FILE: hw/rtl/hash_accumulate_table_quadratic_probe.sv
// Open-addressed accumulation table keyed by exponent, with quadratic probing. One command is
// worked at a time; cmd.ready is high only while the block is idle, and a finished response
// waits in its own register so the next command can be taken meanwhile. An insert first
// finds the home slot (exponent mod size) with a 16-step restoring remainder, one bit per
// cycle, then probes slots; each probe is a read of the slot memory followed by a check.
// A read is a memory read followed by a read-out of the slot; an index beyond the size and
// an unused action go straight to the response. Clearing the table sweeps all MAX_SLOTS
// slots, one per cycle, and the same pass runs right after reset, during which no command
// is accepted (table size writes are taken at any time). The remainder steps and the probe
// wrap share one compare-and-subtract unit. Sizes above MAX_SLOTS act as MAX_SLOTS and 0
// acts as 1.
`include "assert_macros.svh"

module hash_accumulate_table_quadratic_probe #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hatqp_pkg::CFG_W-1:0]   cfg_wr_data,
    hatqp_cmd_if.sink                     cmd,
    hatqp_rsp_if.source                   rsp
);
    import hatqp_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int BW = $clog2(EXPO_W);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_RDOUT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Control registers
    logic [2:0]            state_reg, state_next;
    logic [CFG_W-1:0]      table_size_reg;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  clr_report_reg, clr_report_next;
    logic                  is_read_reg, is_read_next;
    logic [BW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [SW-1:0]         probe_reg, probe_next;
    logic                  out_valid_reg, out_valid_next;

    // Datapath registers
    logic [AW-1:0]         pos_reg, pos_next;
    logic [SW:0]           step_reg, step_next;
    logic [EXPO_W-1:0]     expo_reg, expo_next;
    logic signed [COEF_W-1:0] coef_reg, coef_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  res_valid_reg, res_valid_next;
    logic signed [COEF_W-1:0] res_coef_reg, res_coef_next;
    logic [EXPO_W-1:0]     res_expo_reg, res_expo_next;
    logic [INDEX_W-1:0]    res_pos_reg, res_pos_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_svalid_reg, out_svalid_next;
    logic signed [COEF_W-1:0] out_coef_reg, out_coef_next;
    logic [EXPO_W-1:0]     out_expo_reg, out_expo_next;
    logic [INDEX_W-1:0]    out_pos_reg, out_pos_next;

    // Slot memory
    entry_t                entry_mem [MAX_SLOTS];
    entry_t                rd_data_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    entry_t                mem_wd;

    // Derived values
    logic [SW-1:0]         size_eff;
    logic [SW-1:0]         limit;
    logic [SW:0]           unit_a;
    logic [SW:0]           unit_y;
    logic [AW-1:0]         unit_pos;
    logic signed [COEF_W-1:0] sum;
    logic                  out_free;
    logic                  cmd_fire;
    logic                  idx_in_range;

    // Effective size, clamped to 1..MAX_SLOTS
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_eff = SW'(1);
        end
        else if (32'(table_size_reg) > 32'(MAX_SLOTS))
        begin
            size_eff = SW'(MAX_SLOTS);
        end
        else
        begin
            size_eff = SW'(table_size_reg);
        end
    end

    assign limit = SW'(((SW + 1)'(size_eff) + (SW + 1)'(1)) >> 1);

    // Shared compare-and-subtract unit: remainder step or probe wrap
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            unit_a = (SW + 1)'({pos_reg, expo_reg[bit_cnt_reg]});
        end
        else
        begin
            unit_a = (SW + 1)'(pos_reg) + step_reg;
        end
        unit_y   = (unit_a >= (SW + 1)'(size_eff)) ? unit_a - (SW + 1)'(size_eff) : unit_a;
        unit_pos = AW'(unit_y);
    end

    assign sum          = rd_data_reg.coef + coef_reg;
    assign out_free     = !out_valid_reg || rsp.ready;
    assign cmd.ready    = (state_reg == S_IDLE);
    assign cmd_fire     = cmd.valid && cmd.ready;
    assign idx_in_range = 32'(cmd.slot_index) < 32'(size_eff);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        is_read_next    = is_read_reg;
        bit_cnt_next    = bit_cnt_reg;
        probe_next      = probe_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        expo_next       = expo_reg;
        coef_next       = coef_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_coef_next   = res_coef_reg;
        res_expo_next   = res_expo_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_svalid_next = out_svalid_reg;
        out_coef_next   = out_coef_reg;
        out_expo_next   = out_expo_reg;
        out_pos_next    = out_pos_reg;
        mem_we          = 1'b0;
        mem_wa          = pos_reg;
        mem_wd          = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_SLOTS - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_report_reg ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                // results default to all zero
                res_status_next = ST_DONE;
                res_valid_next  = 1'b0;
                res_coef_next   = '0;
                res_expo_next   = '0;
                res_pos_next    = '0;
                if (cmd_fire)
                begin
                    expo_next    = cmd.exponent;
                    coef_next    = cmd.coefficient;
                    is_read_next = 1'b0;
                    priority if (cmd.action == ACT_CLEAR)
                    begin
                        clr_report_next = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    else if (cmd.action == ACT_INSERT)
                    begin
                        pos_next     = '0;
                        bit_cnt_next = BW'(EXPO_W - 1);
                        state_next   = S_DIV;
                    end
                    else if (cmd.action == ACT_READ)
                    begin
                        res_pos_next = cmd.slot_index;
                        if (idx_in_range)
                        begin
                            pos_next     = AW'(cmd.slot_index);
                            is_read_next = 1'b1;
                            state_next   = S_ISSUE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DIV:
            begin
                // one remainder bit per cycle, most significant first
                pos_next     = unit_pos;
                bit_cnt_next = bit_cnt_reg - BW'(1);
                if (bit_cnt_reg == '0)
                begin
                    step_next  = (SW + 1)'(1);
                    probe_next = '0;
                    state_next = S_ISSUE;
                end
            end

            S_ISSUE:
            begin
                state_next = is_read_reg ? S_RDOUT : S_CHECK;
            end

            S_CHECK:
            begin
                if (!rd_data_reg.occupied)
                begin
                    mem_we          = 1'b1;
                    mem_wd          = '{occupied: 1'b1, expo: expo_reg, coef: coef_reg};
                    res_status_next = ST_NEW;
                    res_valid_next  = 1'b1;
                    res_coef_next   = coef_reg;
                    res_expo_next   = expo_reg;
                    res_pos_next    = INDEX_W'(pos_reg);
                    state_next      = S_DONE;
                end
                else if (rd_data_reg.expo == expo_reg)
                begin
                    mem_we          = 1'b1;
                    mem_wd          = '{occupied: 1'b1, expo: expo_reg, coef: sum};
                    res_status_next = ST_ADDED;
                    res_valid_next  = 1'b1;
                    res_coef_next   = sum;
                    res_expo_next   = expo_reg;
                    res_pos_next    = INDEX_W'(pos_reg);
                    state_next      = S_DONE;
                end
                else if (probe_reg + SW'(1) == limit)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    // next probe: step by the next odd number, wrap once
                    pos_next   = unit_pos;
                    step_next  = step_reg + (SW + 1)'(2);
                    probe_next = probe_reg + SW'(1);
                    state_next = S_ISSUE;
                end
            end

            S_RDOUT:
            begin
                if (rd_data_reg.occupied)
                begin
                    res_valid_next = 1'b1;
                    res_coef_next  = rd_data_reg.coef;
                    res_expo_next  = rd_data_reg.expo;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_svalid_next = res_valid_reg;
                    out_coef_next   = res_coef_reg;
                    out_expo_next   = res_expo_reg;
                    out_pos_next    = res_pos_reg;
                    clr_report_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            table_size_reg <= SIZE_RESET;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            is_read_reg    <= 1'b0;
            bit_cnt_reg    <= '0;
            probe_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            is_read_reg    <= is_read_next;
            bit_cnt_reg    <= bit_cnt_next;
            probe_reg      <= probe_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        expo_reg       <= expo_next;
        coef_reg       <= coef_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_coef_reg   <= res_coef_next;
        res_expo_reg   <= res_expo_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_svalid_reg <= out_svalid_next;
        out_coef_reg   <= out_coef_next;
        out_expo_reg   <= out_expo_next;
        out_pos_reg    <= out_pos_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= entry_mem[pos_reg];
    end

    // Response channel
    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.slot_valid       = out_svalid_reg;
    assign rsp.slot_coefficient = out_coef_reg;
    assign rsp.slot_exponent    = out_expo_reg;
    assign rsp.slot_position    = out_pos_reg;

    // Checks
    `HATQP_ASSERT_ALL(a_busy_in_clear, clk, (state_reg == S_CLEAR) |-> !cmd.ready, "ready during clear sweep")
    `HATQP_ASSERT_RST(a_busy_after_accept, clk, rst_n, cmd_fire |=> !cmd.ready, "ready right after accept")
    `HATQP_ASSERT_RST(a_probe_bound, clk, rst_n, (state_reg == S_CHECK) |-> (probe_reg < limit), "probe count past limit")
    `HATQP_ASSERT_RST(a_pos_in_table, clk, rst_n, (state_reg == S_CHECK && !is_read_reg) |-> (32'(pos_reg) < 32'(size_eff)), "probe slot beyond size")
    `HATQP_ASSERT_RST(a_rsp_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "response loaded outside done")

endmodule
